// ----- src/lcgd_pkg.sv -----
// Shared types, constants and the microcode ROM of the LCG draw engine.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lcgd_pkg;

  localparam int MAX_POISSON_COUNT = 1023;

  localparam logic [31:0] RESET_MULT = 32'd2743;
  localparam logic [31:0] RESET_INC  = 32'd5923;
  localparam logic signed [31:0] WARM_LOW  = 32'sd7;
  localparam logic signed [31:0] WARM_HIGH = 32'sd29;

  // counter must hold the Poisson limit and the largest warm-up count
  localparam int CNT_BITS = $clog2(MAX_POISSON_COUNT + 1);
  localparam int CNT_W    = (CNT_BITS > 5) ? CNT_BITS : 5;

  localparam int STEP_W = 6;
  localparam int MUL_W  = 65;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MULT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INC  = 1'd1;

  typedef enum logic [1:0] {
    ACT_SEED = 2'd0,
    ACT_RAW  = 2'd1,
    ACT_INT  = 2'd2,
    ACT_POIS = 2'd3
  } act_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] seed_value;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic [30:0]        poisson_limit;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               capped;
  } rsp_t;

  typedef enum logic [2:0] {
    SQ_NEXT,
    SQ_JUMP,
    SQ_FETCH,
    SQ_IF_LE,
    SQ_IF_CMAX,
    SQ_IF_CZERO,
    SQ_IF_BOOT,
    SQ_EMIT
  } seq_cond_t;

  typedef enum logic [1:0] {MUL_NONE, MUL_LCG, MUL_RANGE, MUL_POIS} mul_op_t;
  typedef enum logic [1:0] {SEED_HOLD, SEED_UPD, SEED_LOAD} seed_op_t;
  typedef enum logic [1:0] {BND_HOLD, BND_ORDER, BND_WARM, BND_SPAN} bnd_op_t;
  typedef enum logic [2:0] {ACC_HOLD, ACC_RANGE, ACC_SEED, ACC_FRAC, ACC_CNT} acc_op_t;
  typedef enum logic [2:0] {CNT_HOLD, CNT_CLEAR, CNT_INC, CNT_DEC, CNT_LOAD} cnt_op_t;
  typedef enum logic [1:0] {PROD_HOLD, PROD_FRAC, PROD_MUL} prod_op_t;

  typedef struct packed {
    seq_cond_t          cond;
    logic [STEP_W-1:0]  target;
    mul_op_t            mul;
    seed_op_t           seed;
    bnd_op_t            bnd;
    acc_op_t            acc;
    cnt_op_t            cnt;
    prod_op_t           prod;
    logic               cap;
  } uword_t;

  // sequencer -> datapath
  typedef struct packed {
    uword_t word;
    logic   load;
    logic   emit;
    logic   boot;
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic prod_gt;
    logic cnt_zero;
    logic cnt_max;
  } stat_t;

  // program entry points and loop heads
  localparam logic [STEP_W-1:0] ST_FETCH = 6'd0;
  localparam logic [STEP_W-1:0] ST_RAW   = 6'd1;
  localparam logic [STEP_W-1:0] ST_INT   = 6'd5;
  localparam logic [STEP_W-1:0] ST_SEED  = 6'd10;
  localparam logic [STEP_W-1:0] ST_WARM  = 6'd11;
  localparam logic [STEP_W-1:0] ST_WLOOP = 6'd16;
  localparam logic [STEP_W-1:0] ST_WEND  = 6'd19;
  localparam logic [STEP_W-1:0] ST_POIS  = 6'd22;
  localparam logic [STEP_W-1:0] ST_PLOOP = 6'd25;
  localparam logic [STEP_W-1:0] ST_PCAP  = 6'd31;
  localparam logic [STEP_W-1:0] ST_PDONE = 6'd33;

  function automatic uword_t uw(input seq_cond_t c, input logic [STEP_W-1:0] t,
                                input mul_op_t m, input seed_op_t s, input bnd_op_t b,
                                input acc_op_t a, input cnt_op_t n, input prod_op_t p,
                                input logic cap);
    uword_t w;
    w.cond   = c;
    w.target = t;
    w.mul    = m;
    w.seed   = s;
    w.bnd    = b;
    w.acc    = a;
    w.cnt    = n;
    w.prod   = p;
    w.cap    = cap;
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] entry(input act_t a);
    logic [STEP_W-1:0] e;
    case (a)
      ACT_SEED: e = ST_SEED;
      ACT_RAW:  e = ST_RAW;
      ACT_INT:  e = ST_INT;
      ACT_POIS: e = ST_POIS;
      default:  e = ST_FETCH;
    endcase
    return e;
  endfunction

  // microcode ROM; a draw is MUL_LCG followed by SEED_UPD
  function automatic uword_t ucode(input logic [STEP_W-1:0] addr);
    uword_t w;
    case (addr)
      // idle: wait for a transfer, dispatch on action
      6'd0:  w = uw(SQ_FETCH,   ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      // raw fraction
      6'd1:  w = uw(SQ_NEXT,    ST_FETCH, MUL_LCG,   SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd2:  w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_UPD,  BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd3:  w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_FRAC,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd4:  w = uw(SQ_EMIT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      // integer in range
      6'd5:  w = uw(SQ_NEXT,    ST_FETCH, MUL_LCG,   SEED_HOLD, BND_ORDER, ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd6:  w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_UPD,  BND_SPAN,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd7:  w = uw(SQ_NEXT,    ST_FETCH, MUL_RANGE, SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd8:  w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_RANGE, CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd9:  w = uw(SQ_EMIT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      // seed load, then warm-up (reset enters at ST_WARM)
      6'd10: w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_LOAD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd11: w = uw(SQ_NEXT,    ST_FETCH, MUL_LCG,   SEED_HOLD, BND_WARM,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd12: w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_UPD,  BND_SPAN,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd13: w = uw(SQ_NEXT,    ST_FETCH, MUL_RANGE, SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd14: w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_RANGE, CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd15: w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_LOAD,  PROD_HOLD, 1'b0);
      6'd16: w = uw(SQ_IF_CZERO, ST_WEND, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd17: w = uw(SQ_NEXT,    ST_FETCH, MUL_LCG,   SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_DEC,   PROD_HOLD, 1'b0);
      6'd18: w = uw(SQ_JUMP,    ST_WLOOP, MUL_NONE,  SEED_UPD,  BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd19: w = uw(SQ_IF_BOOT, ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd20: w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_SEED,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd21: w = uw(SQ_EMIT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      // Poisson
      6'd22: w = uw(SQ_NEXT,    ST_FETCH, MUL_LCG,   SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_CLEAR, PROD_HOLD, 1'b0);
      6'd23: w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_UPD,  BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd24: w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_FRAC, 1'b0);
      6'd25: w = uw(SQ_IF_LE,   ST_PDONE, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd26: w = uw(SQ_IF_CMAX, ST_PCAP,  MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd27: w = uw(SQ_NEXT,    ST_FETCH, MUL_LCG,   SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_INC,   PROD_HOLD, 1'b0);
      6'd28: w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_UPD,  BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd29: w = uw(SQ_NEXT,    ST_FETCH, MUL_POIS,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd30: w = uw(SQ_JUMP,    ST_PLOOP, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_MUL,  1'b0);
      6'd31: w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_CNT,   CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd32: w = uw(SQ_EMIT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b1);
      6'd33: w = uw(SQ_NEXT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_CNT,   CNT_HOLD,  PROD_HOLD, 1'b0);
      6'd34: w = uw(SQ_EMIT,    ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
      default: w = uw(SQ_JUMP,  ST_FETCH, MUL_NONE,  SEED_HOLD, BND_HOLD,  ACC_HOLD,  CNT_HOLD,  PROD_HOLD, 1'b0);
    endcase
    return w;
  endfunction

endpackage

// ----- src/lcgd_sequencer.sv -----
// Microcode sequencer: step counter, ROM lookup, jumps and channel handshakes.
// Depends on lcgd_pkg.
`timescale 1ns / 1ps

module lcgd_sequencer
  import lcgd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  logic  [1:0] req_action,
  output logic  req_stall,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  input  stat_t stat,
  output ctl_t  ctl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              boot;
  logic              boot_next;
  logic              rsp_valid_next;
  uword_t            w;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_WARM;
      boot      <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      step      <= step_next;
      boot      <= boot_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    w              = ucode(step);
    step_next      = step + STEP_W'(1);
    boot_next      = boot;
    req_stall      = 1'b1;
    ctl.load       = 1'b0;
    ctl.emit       = 1'b0;
    rsp_valid_next = rsp_valid && rsp_stall;
    case (w.cond)
      SQ_NEXT: begin
      end
      SQ_JUMP: begin
        step_next = w.target;
      end
      SQ_FETCH: begin
        req_stall = 1'b0;
        if (req_valid) begin
          ctl.load  = 1'b1;
          step_next = entry(act_t'(req_action));
        end else begin
          step_next = step;
        end
      end
      SQ_IF_LE: begin
        if (!stat.prod_gt) step_next = w.target;
      end
      SQ_IF_CMAX: begin
        if (stat.cnt_max) step_next = w.target;
      end
      SQ_IF_CZERO: begin
        if (stat.cnt_zero) step_next = w.target;
      end
      SQ_IF_BOOT: begin
        if (boot) begin
          step_next = w.target;
          boot_next = 1'b0;
        end
      end
      SQ_EMIT: begin
        // result register free or being drained this cycle
        if (!rsp_valid || !rsp_stall) begin
          ctl.emit       = 1'b1;
          rsp_valid_next = 1'b1;
          step_next      = w.target;
        end else begin
          step_next = step;
        end
      end
      default: begin
        step_next = ST_FETCH;
      end
    endcase
    ctl.word = w;
    ctl.boot = boot;
  end

endmodule

// ----- src/lcgd_datapath.sv -----
// Datapath: config registers, seed, shared 33x32 multiplier, bounds, counter,
// Poisson product and the result register. Depends on lcgd_pkg.
`timescale 1ns / 1ps

module lcgd_datapath
  import lcgd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  input  req_t                 req,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output stat_t                stat,
  output rsp_t                 rsp
);

  logic [31:0]        mult;
  logic [31:0]        inc;
  logic [31:0]        mult_eff;
  logic [31:0]        inc_eff;
  logic [31:0]        seed;
  req_t               in_r;
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic [32:0]        span;
  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic [MUL_W-1:0]   mulp;
  logic [31:0]        acc;
  logic [30:0]        prod;
  logic [CNT_W-1:0]   cnt;

  // the post-reset warm-up runs with the reset coefficients
  assign mult_eff = ctl.boot ? RESET_MULT : mult;
  assign inc_eff  = ctl.boot ? RESET_INC  : inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= RESET_MULT;
      inc  <= RESET_INC;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MULT: mult <= cfg_data;
        REG_INC:  inc  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ctl.word.mul)
      MUL_LCG: begin
        mul_a = {1'b0, seed};
        mul_b = mult_eff;
      end
      MUL_RANGE: begin
        mul_a = span;
        mul_b = {1'b0, seed[30:0]};
      end
      MUL_POIS: begin
        mul_a = {2'b0, prod};
        mul_b = {1'b0, seed[30:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.word.mul != MUL_NONE) mulp <= {32'b0, mul_a} * {33'b0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'd1;
    end else begin
      case (ctl.word.seed)
        SEED_UPD:  seed <= mulp[31:0] + inc_eff;
        SEED_LOAD: seed <= $unsigned(in_r.seed_value);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) in_r <= req;
  end

  always_ff @(posedge clk) begin
    case (ctl.word.bnd)
      BND_ORDER: begin
        if (in_r.low_bound > in_r.high_bound) begin
          lo <= in_r.high_bound;
          hi <= in_r.low_bound;
        end else begin
          lo <= in_r.low_bound;
          hi <= in_r.high_bound;
        end
      end
      BND_WARM: begin
        lo <= WARM_LOW;
        hi <= WARM_HIGH;
      end
      BND_SPAN: begin
        // hi >= lo here, so the 33-bit span is 1 .. 2^32
        span <= {hi[31], hi} - {lo[31], lo} + 33'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctl.word.acc)
      ACC_RANGE: acc <= $unsigned(lo) + mulp[62:31];
      ACC_SEED:  acc <= seed;
      ACC_FRAC:  acc <= {1'b0, seed[30:0]};
      ACC_CNT:   acc <= {{(32-CNT_W){1'b0}}, cnt};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctl.word.cnt)
      CNT_CLEAR: cnt <= '0;
      CNT_INC:   cnt <= cnt + CNT_W'(1);
      CNT_DEC:   cnt <= cnt - CNT_W'(1);
      CNT_LOAD:  cnt <= acc[CNT_W-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctl.word.prod)
      PROD_FRAC: prod <= seed[30:0];
      PROD_MUL:  prod <= mulp[61:31];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rsp.value  <= $signed(acc);
      rsp.capped <= ctl.word.cap;
    end
  end

  assign stat.prod_gt  = prod > in_r.poisson_limit;
  assign stat.cnt_zero = cnt == '0;
  assign stat.cnt_max  = cnt >= CNT_W'(MAX_POISSON_COUNT);

endmodule

// ----- src/lcg_random_draw_engine_core.sv -----
// LCG random draw engine, top level: sequencer plus datapath, and checks.
// Depends on lcgd_pkg, lcgd_sequencer and lcgd_datapath.
`timescale 1ns / 1ps

// 32-bit linear congruential generator serving one request at a time. Each
// draw is a pass through the shared 33x32 multiplier followed by the seed
// add, and a microcode sequencer strings draws into the requested action:
// raw fraction, integer in range, seed load with n = 7..29 discarded draws,
// or a Poisson count k. After reset a warm-up of the same kind as a seed
// load runs with the reset coefficients before the first request is taken.
// A finished result sits in an output register, so the next request can
// start while it waits.
module lcg_random_draw_engine_core
  import lcgd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  ctl_t  ctl;
  stat_t stat;

  lcgd_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_action (req.action),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .stat       (stat),
    .ctl        (ctl)
  );

  lcgd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .req       (req),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .rsp       (rsp)
  );

  // a saturated Poisson result always carries the maximum count
  a_capped_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.capped |-> rsp.value == 32'(MAX_POISSON_COUNT))
    else $error("capped result without maximum count");

  // no request is taken before the post-reset warm-up has finished
  a_no_load_in_boot: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> !ctl.boot)
    else $error("request accepted during warm-up");

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> !rsp_valid || !rsp_stall)
    else $error("result register overwritten");

  // after a result is emitted it is presented on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> rsp_valid)
    else $error("emitted result not presented");

endmodule

// ----- tb/lcg_draw_checker.sv -----
// Scoreboard for lcg_random_draw_engine_core: keeps its own copy of the generator
// state and coefficients, predicts each draw and compares it with every result transfer.
// Depends on lcgd_pkg.
`timescale 1ns / 1ps

module lcg_draw_checker
  import lcgd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  req_t                 req,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  rsp_t                 rsp,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   errors,
  output int                   pending
);

  logic [31:0] mult_q;
  logic [31:0] inc_q;
  logic [31:0] lcg_seed;
  rsp_t        draws_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_bad(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    errors++;
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  // one congruential step; the low 31 bits are the Q0.31 fraction
  function automatic longint next_fraction();
    lcg_seed = lcg_seed * mult_q + inc_q;
    return longint'(lcg_seed[30:0]);
  endfunction

  function automatic logic [31:0] ranged_draw(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    longint lo;
    longint hi;
    longint span;
    lo   = (a > b) ? b : a;
    hi   = (a > b) ? a : b;
    span = hi - lo + 1;
    return 32'(lo + ((span * next_fraction()) >> 31));
  endfunction

  function automatic void warm_up();
    int unsigned n;
    n = ranged_draw(WARM_LOW, WARM_HIGH);
    repeat (n) void'(next_fraction());
  endfunction

  function automatic rsp_t draw_result(input req_t r);
    rsp_t   res;
    longint prod;
    int     count;
    logic   done;
    res = '0;
    case (act_t'(r.action))
      ACT_SEED: begin
        lcg_seed = r.seed_value;
        warm_up();
        res.value = lcg_seed;
      end
      ACT_RAW: res.value = 32'(next_fraction());
      ACT_INT: res.value = ranged_draw(r.low_bound, r.high_bound);
      ACT_POIS: begin
        prod  = next_fraction();
        count = 0;
        done  = 1'b0;
        while (!done && prod > longint'(r.poisson_limit)) begin
          if (count >= MAX_POISSON_COUNT) begin
            res.capped = 1'b1;
            done       = 1'b1;
          end else begin
            count++;
            prod = (prod * next_fraction()) >> 31;
          end
        end
        res.value = count;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      // block runs its own warm-up with the reset coefficients
      mult_q   = RESET_MULT;
      inc_q    = RESET_INC;
      lcg_seed = 32'd1;
      warm_up();
      draws_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MULT) mult_q = cfg_data;
        else if (cfg_index == REG_INC) inc_q = cfg_data;
      end
      if (rsp_valid && !rsp_stall) begin
        if (draws_q.size() == 0) begin
          report_bad("unexpected result", 32'd0, rsp.value);
        end else begin
          want = draws_q.pop_front();
          if (rsp.value !== want.value) report_bad("value", want.value, rsp.value);
          if (rsp.capped !== want.capped)
            report_bad("capped", 32'(want.capped), 32'(rsp.capped));
        end
      end
      if (req_valid && !req_stall) draws_q.push_back(draw_result(req));
    end
    pending <= draws_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for lcg_random_draw_engine_core: clock, reset, request and stall
// stimulus, coefficient phases and the verdict. Depends on lcgd_pkg and lcg_draw_checker.
`timescale 1ns / 1ps

module tb_top
  import lcgd_pkg::*;
();

  localparam int IDLE_LIMIT      = 40000;
  localparam int ITEMS_PER_PHASE = 194;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  req_t                 req;
  logic                 rsp_valid;
  logic                 rsp_stall;
  rsp_t                 rsp;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int errors;
  int pending;
  int idle_cycles = 0;
  int burst_left  = 0;

  lcg_random_draw_engine_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcg_draw_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: cycles without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // result side backpressure, in stretches of varying density
  initial begin : stall_gen
    int mode;
    int stretch;
    rsp_stall = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(5, 80);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 3) == 0);
          2: rsp_stall <= ($urandom_range(0, 9) < 7);
          default: rsp_stall <= 1'b1;
        endcase
      end
    end
  end

  function automatic req_t any_req(input act_t a);
    req_t r;
    r.action        = a;
    r.seed_value    = $urandom;
    r.low_bound     = $urandom;
    r.high_bound    = $urandom;
    r.poisson_limit = 31'($urandom);
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   pick;
    r    = any_req(act_t'($urandom_range(0, 3)));
    pick = $urandom_range(0, 9);
    if (pick < 3) r.high_bound = r.low_bound + $urandom_range(0, 20);
    else if (pick == 3) r.low_bound = 32'h8000_0000 + $urandom_range(0, 3);
    else if (pick == 4) r.high_bound = 32'h7FFF_FFFF - $urandom_range(0, 3);
    // limits spread over many means; zero and near-one thresholds now and then
    pick = $urandom_range(0, 9);
    if (pick == 0) r.poisson_limit = '0;
    else if (pick == 1) r.poisson_limit = '1;
    else if (pick < 7) r.poisson_limit = 31'($urandom >> $urandom_range(1, 31));
    return r;
  endfunction

  // expects to be called at a falling edge; returns at the falling edge after the transfer
  task automatic send_req(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_fields(input act_t a, input logic [31:0] v1, input logic [31:0] v2);
    req_t r;
    r = any_req(a);
    case (a)
      ACT_SEED: r.seed_value = v1;
      ACT_INT: begin
        r.low_bound  = v1;
        r.high_bound = v2;
      end
      ACT_POIS: r.poisson_limit = v1[30:0];
      default: ;
    endcase
    send_req(r);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic reconfigure(input logic [31:0] mult, input logic [31:0] inc);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_MULT;
    cfg_data  <= mult;
    @(negedge clk);
    cfg_index <= REG_INC;
    cfg_data  <= inc;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] mult_tab[6];
    logic [31:0] inc_tab[6];
    mult_tab = '{RESET_MULT, 32'd1664525, 32'd22695477, 32'h41C6_4E6D, 32'hFFFF_FFFF, 32'd1};
    inc_tab  = '{RESET_INC, 32'd1013904223, 32'd1, 32'd12345, 32'hFFFF_FFFF, 32'h9E37_79B9};

    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_write = 1'b0;
    cfg_index = REG_MULT;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset coefficients: range and seed extremes, plus raw and Poisson draws
    send_fields(ACT_RAW, 32'd0, 32'd0);
    send_fields(ACT_INT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_fields(ACT_INT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_fields(ACT_INT, 32'd0, 32'd0);
    send_fields(ACT_INT, 32'h8000_0000, 32'h8000_0000);
    send_fields(ACT_INT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_fields(ACT_INT, 32'hFFFF_FFFB, 32'd5);
    send_fields(ACT_SEED, 32'd0, 32'd0);
    send_fields(ACT_SEED, 32'hFFFF_FFFF, 32'd0);
    send_fields(ACT_SEED, 32'h8000_0000, 32'd0);
    send_fields(ACT_SEED, 32'h7FFF_FFFF, 32'd0);
    send_fields(ACT_POIS, 32'd0, 32'd0);
    send_fields(ACT_POIS, 32'h7FFF_FFFF, 32'd0);
    send_fields(ACT_POIS, 32'h4000_0000, 32'd0);

    // frozen seed with fraction all ones: product drops by one per step,
    // so the limits below land right around the count ceiling
    reconfigure(32'd1, 32'd0);
    send_fields(ACT_SEED, 32'hFFFF_FFFF, 32'd0);
    send_fields(ACT_POIS, 32'h7FFF_FBFF, 32'd0);
    send_fields(ACT_POIS, 32'h7FFF_FC00, 32'd0);
    send_fields(ACT_POIS, 32'h7FFF_FC01, 32'd0);
    send_fields(ACT_RAW, 32'd0, 32'd0);

    reconfigure(32'd0, 32'd0);
    send_fields(ACT_RAW, 32'd0, 32'd0);
    send_fields(ACT_INT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_fields(ACT_POIS, 32'd0, 32'd0);
    send_fields(ACT_SEED, $urandom, 32'd0);

    reconfigure(32'hFFFF_FFFF, 32'd0);
    send_fields(ACT_RAW, 32'd0, 32'd0);
    send_fields(ACT_POIS, 32'd0, 32'd0);

    for (int p = 0; p < 8; p++) begin
      if (p < 6) reconfigure(mult_tab[p], inc_tab[p]);
      else if (p == 6) reconfigure($urandom, $urandom);
      else reconfigure($urandom | 32'd1, $urandom);
      repeat (ITEMS_PER_PHASE) send_req(random_req());
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/lcgd_pkg.sv
src/lcgd_sequencer.sv
src/lcgd_datapath.sv
src/lcg_random_draw_engine_core.sv
tb/lcg_draw_checker.sv
tb/tb_top.sv
